// File: rtl/assert_macros.svh
// Assertion macros for the RTL file that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Implication check, sampled on the rising clock edge, off during reset.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication check.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Condition that must never hold.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`else

`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

// File: rtl/ssym_pkg.sv
// Shared types and constants of the scoped symbol stack.
`default_nettype none

package ssym_pkg;

    // Sizing of the entry store.
    localparam int TABLE_ENTRIES = 1024;
    localparam int KEY_BITS      = 64;
    localparam int DEPTH_BITS    = 8;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int CNT_W         = IDX_W + 1;

    // Fixed field widths of the request and response beats.
    localparam int F_REQ_W   = 3;
    localparam int F_KEY_W   = 64;
    localparam int F_IDX_W   = 10;
    localparam int F_DEPTH_W = 8;
    localparam int F_CNT_W   = 11;
    localparam int F_STAT_W  = 3;

    typedef enum logic [F_REQ_W-1:0] {
        OP_PUSH  = 3'd0,
        OP_POP   = 3'd1,
        OP_PEEK  = 3'd2,
        OP_READ  = 3'd3,
        OP_FIND  = 3'd4,
        OP_ENTER = 3'd5,
        OP_EXIT  = 3'd6,
        OP_CLEAR = 3'd7
    } t_op;

    typedef enum logic [F_STAT_W-1:0] {
        STAT_OK        = 3'd0,
        STAT_FULL      = 3'd1,
        STAT_EMPTY     = 3'd2,
        STAT_BAD_INDEX = 3'd3,
        STAT_DEPTH_LOW = 3'd4,
        STAT_DEPTH_OVF = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_READ,
        S_SCAN,
        S_DONE
    } t_state;

    // Controller to datapath.
    typedef struct packed {
        logic capture;
        logic exec;
        logic take_read;
        logic scan;
        logic publish;
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic exec_read;
        logic exec_scan;
        logic scan_done;
    } t_sts;

    typedef struct packed {
        logic [F_KEY_W-1:0]   key;
        logic [F_DEPTH_W-1:0] depth;
        logic [F_IDX_W-1:0]   found_index;
        logic                 found;
        logic [F_CNT_W-1:0]   count;
        t_status              status;
    } t_result;

    typedef struct packed {
        logic [DEPTH_BITS-1:0] depth;
        logic [KEY_BITS-1:0]   key;
    } t_entry;

endpackage

`default_nettype wire

// File: rtl/ssym_if.sv
// Request and response channel interfaces of the scoped symbol stack.
`default_nettype none

interface ssym_req_if import ssym_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [F_REQ_W-1:0]   req_type;
    logic [F_KEY_W-1:0]   name_key;
    logic [F_IDX_W-1:0]   entry_index;

    modport source (output valid, output req_type, output name_key, output entry_index,
                    input ready);
    modport sink   (input valid, input req_type, input name_key, input entry_index,
                    output ready);
endinterface

interface ssym_rsp_if import ssym_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [F_KEY_W-1:0]   out_key;
    logic [F_DEPTH_W-1:0] out_depth;
    logic [F_IDX_W-1:0]   found_index;
    logic                 found;
    logic [F_CNT_W-1:0]   entry_count;
    logic [F_STAT_W-1:0]  status;

    modport source (output valid, output out_key, output out_depth, output found_index,
                    output found, output entry_count, output status, input ready);
    modport sink   (input valid, input out_key, input out_depth, input found_index,
                    input found, input entry_count, input status, output ready);
endinterface

`default_nettype wire

// File: rtl/ssym_ctrl.sv
// Controller state machine: sequences each request and owns the response valid.
`default_nettype none

module ssym_ctrl import ssym_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_req_valid,
    output logic      o_req_ready,
    output logic      o_rsp_valid,
    input  wire logic i_rsp_ready,
    output t_cmd      o_cmd,
    input  wire t_sts i_sts
);

    t_state r_state, n_state;
    logic   r_out_vld, n_out_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_req_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                priority if (i_sts.exec_read) n_state = S_READ;
                else if (i_sts.exec_scan)     n_state = S_SCAN;
                else                          n_state = S_DONE;
            end
            S_READ: begin
                o_cmd.take_read = 1'b1;
                n_state         = S_DONE;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_done) n_state = S_DONE;
            end
            S_DONE: begin
                // hold the finished result until the output slot frees up
                if (!r_out_vld || i_rsp_ready) begin
                    o_cmd.publish = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        priority if (o_cmd.publish)        n_out_vld = 1'b1;
        else if (r_out_vld && i_rsp_ready) n_out_vld = 1'b0;
        else                               n_out_vld = r_out_vld;
    end

    assign o_rsp_valid = r_out_vld;

endmodule

`default_nettype wire

// File: rtl/ssym_dp.sv
// Datapath: entry memory, top and scope registers, scan walker and result registers.
`default_nettype none

module ssym_dp import ssym_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_cmd                 i_cmd,
    output t_sts                      o_sts,
    input  wire logic [F_REQ_W-1:0]   i_req_type,
    input  wire logic [F_KEY_W-1:0]   i_name_key,
    input  wire logic [F_IDX_W-1:0]   i_entry_index,
    output t_result                   o_res
);

    // Entry memory, one write and one registered read per cycle.
    t_entry mem [TABLE_ENTRIES];
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    t_entry           mem_wdata;
    logic             mem_re;
    logic [IDX_W-1:0] mem_raddr;
    t_entry           r_rdata;

    logic [CNT_W-1:0]      r_top, n_top;
    logic [DEPTH_BITS-1:0] r_scope, n_scope;
    logic [CNT_W-1:0]      r_ptr, n_ptr;
    logic                  r_rd_vld, n_rd_vld;
    logic [IDX_W-1:0]      r_rd_idx, n_rd_idx;
    t_op                   r_op;
    logic [KEY_BITS-1:0]   r_key;
    logic [F_IDX_W-1:0]    r_idx;
    t_result               r_res, n_res;
    t_result               r_out;

    logic full, empty, idx_bad, depth_max, depth_zero;
    logic key_hit, depth_hit, is_find, stop, scan_done;

    function automatic t_result mk_res(input logic [KEY_BITS-1:0]   key,
                                       input logic [DEPTH_BITS-1:0] depth,
                                       input logic [IDX_W-1:0]      fidx,
                                       input logic                  hit,
                                       input logic [CNT_W-1:0]      cnt,
                                       input t_status               st);
        t_result r;
        r.key         = F_KEY_W'(key);
        r.depth       = F_DEPTH_W'(depth);
        r.found_index = F_IDX_W'(fidx);
        r.found       = hit;
        r.count       = F_CNT_W'(cnt);
        r.status      = st;
        return r;
    endfunction

    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_waddr] <= mem_wdata;
    end

    always_ff @(posedge i_clk) begin
        if (mem_re) r_rdata <= mem[mem_raddr];
    end

    assign full       = (r_top == CNT_W'(TABLE_ENTRIES));
    assign empty      = (r_top == '0);
    assign idx_bad    = (CNT_W'(r_idx) >= r_top);
    assign depth_max  = (r_scope == {DEPTH_BITS{1'b1}});
    assign depth_zero = (r_scope == '0);

    assign is_find   = (r_op == OP_FIND);
    assign key_hit   = r_rd_vld && (r_rdata.key == r_key);
    assign depth_hit = r_rd_vld && (r_rdata.depth == r_scope);
    // find stops on the newest match, exit scope on the first entry of an outer scope
    assign stop      = is_find ? key_hit : (r_rd_vld && !depth_hit);
    assign scan_done = stop || (!r_rd_vld && (r_ptr == '0));

    assign o_sts.exec_read = (((r_op == OP_POP) || (r_op == OP_PEEK)) && !empty)
                           || ((r_op == OP_READ) && !idx_bad);
    assign o_sts.exec_scan = (r_op == OP_FIND) || ((r_op == OP_EXIT) && !depth_zero);
    assign o_sts.scan_done = scan_done;

    always_comb begin
        n_top     = r_top;
        n_scope   = r_scope;
        n_ptr     = r_ptr;
        n_rd_vld  = r_rd_vld;
        n_rd_idx  = r_rd_idx;
        n_res     = r_res;
        mem_we    = 1'b0;
        mem_waddr = IDX_W'(r_top);
        mem_wdata = '{depth: r_scope, key: r_key};
        mem_re    = 1'b0;
        mem_raddr = IDX_W'(r_top - 1'b1);

        if (i_cmd.exec) begin
            unique case (r_op)
                OP_PUSH: begin
                    if (full) begin
                        n_res = mk_res('0, r_scope, '0, 1'b0, r_top, STAT_FULL);
                    end else begin
                        mem_we = 1'b1;
                        n_top  = r_top + 1'b1;
                        n_res  = mk_res(r_key, r_scope, '0, 1'b0, r_top + 1'b1, STAT_OK);
                    end
                end
                OP_POP, OP_PEEK: begin
                    if (empty) begin
                        n_res = mk_res('0, r_scope, '0, 1'b0, r_top, STAT_EMPTY);
                    end else begin
                        mem_re = 1'b1;
                        if (r_op == OP_POP) n_top = r_top - 1'b1;
                    end
                end
                OP_READ: begin
                    if (idx_bad) begin
                        n_res = mk_res('0, r_scope, '0, 1'b0, r_top, STAT_BAD_INDEX);
                    end else begin
                        mem_re    = 1'b1;
                        mem_raddr = IDX_W'(r_idx);
                    end
                end
                OP_FIND, OP_EXIT: begin
                    if ((r_op == OP_EXIT) && depth_zero) begin
                        n_res = mk_res('0, r_scope, '0, 1'b0, r_top, STAT_DEPTH_LOW);
                    end else begin
                        n_ptr    = r_top;
                        n_rd_vld = 1'b0;
                    end
                end
                OP_ENTER: begin
                    if (depth_max) begin
                        n_res = mk_res('0, r_scope, '0, 1'b0, r_top, STAT_DEPTH_OVF);
                    end else begin
                        n_scope = r_scope + 1'b1;
                        n_res   = mk_res('0, r_scope + 1'b1, '0, 1'b0, r_top, STAT_OK);
                    end
                end
                OP_CLEAR: begin
                    n_top = '0;
                    n_res = mk_res('0, r_scope, '0, 1'b0, '0, STAT_OK);
                end
                default: n_res = r_res;
            endcase
        end

        if (i_cmd.take_read) begin
            n_res = mk_res(r_rdata.key, r_rdata.depth, '0, 1'b0, r_top, STAT_OK);
        end

        if (i_cmd.scan) begin
            // read ahead one entry per cycle, compare the previous one
            if (r_ptr != '0) begin
                mem_re    = 1'b1;
                mem_raddr = IDX_W'(r_ptr - 1'b1);
                n_ptr     = r_ptr - 1'b1;
                n_rd_vld  = 1'b1;
                n_rd_idx  = IDX_W'(r_ptr - 1'b1);
            end else begin
                n_rd_vld = 1'b0;
            end
            // drop an entry of the scope being left
            if (!is_find && depth_hit) n_top = CNT_W'(r_rd_idx);
            if (scan_done) begin
                if (is_find) begin
                    n_res = mk_res('0, r_scope, key_hit ? r_rd_idx : '0, key_hit, r_top,
                                   STAT_OK);
                end else begin
                    n_scope = r_scope - 1'b1;
                    n_res   = mk_res('0, r_scope - 1'b1, '0, 1'b0, r_top, STAT_OK);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top    <= '0;
            r_scope  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_top    <= n_top;
            r_scope  <= n_scope;
            r_rd_vld <= n_rd_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr    <= n_ptr;
        r_rd_idx <= n_rd_idx;
        r_res    <= n_res;
        if (i_cmd.capture) begin
            r_op  <= t_op'(i_req_type);
            r_key <= i_name_key[KEY_BITS-1:0];
            r_idx <= i_entry_index;
        end
        if (i_cmd.publish) r_out <= r_res;
    end

    assign o_res = r_out;

endmodule

`default_nettype wire

// File: rtl/scoped_symbol_stack.sv
// Top level of the scoped symbol stack: controller, datapath and channel ports.
`default_nettype none
`include "assert_macros.svh"

// Stack of up to TABLE_ENTRIES symbol entries (name key plus the scope depth it
// was pushed at) with a current scope depth, serving one request at a time.
// Each request yields exactly one response beat. Push, enter scope, clear and
// every error case go from accept through the execute and done states to the
// response; pop, peek and read by index pass the read state as well, since the
// entry memory has one registered read port. Find and exit scope walk the
// entries from the top down through that port, one entry per cycle, until the
// walk stops or runs past the bottom entry. A new request is taken in the cycle
// after the previous response moves to the output register, which holds it
// until the sink takes it. The entry memory needs no clearing after reset.
module scoped_symbol_stack import ssym_pkg::*; (
    input wire logic  i_clk,
    input wire logic  i_rst_n,
    ssym_req_if.sink  i_req,
    ssym_rsp_if.source o_rsp
);

    t_cmd    cmd;
    t_sts    sts;
    t_result res;

    ssym_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .o_rsp_valid (o_rsp.valid),
        .i_rsp_ready (o_rsp.ready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    ssym_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_req_type    (i_req.req_type),
        .i_name_key    (i_req.name_key),
        .i_entry_index (i_req.entry_index),
        .o_res         (res)
    );

    assign o_rsp.out_key     = res.key;
    assign o_rsp.out_depth   = res.depth;
    assign o_rsp.found_index = res.found_index;
    assign o_rsp.found       = res.found;
    assign o_rsp.entry_count = res.count;
    assign o_rsp.status      = res.status;

    `ASSERT_NEVER(a_one_cmd, i_clk, i_rst_n, !$onehot0(cmd), "more than one datapath command")
    `ASSERT_NEXT(a_exec_follows, i_clk, i_rst_n, i_req.valid && i_req.ready, cmd.exec, "accepted beat not executed")
    `ASSERT_IMPL(a_publish_free, i_clk, i_rst_n, cmd.publish, !o_rsp.valid || o_rsp.ready, "response overwritten")
    `ASSERT_IMPL(a_count_range, i_clk, i_rst_n, o_rsp.valid, o_rsp.entry_count <= F_CNT_W'(TABLE_ENTRIES), "entry count beyond table")

endmodule

`default_nettype wire

// File: bench/tb.sv
// Testbench for the scoped symbol stack: directed and random requests, checked per response.
`timescale 1ns / 100ps

module tb;
    import ssym_pkg::*;

    logic i_clk;
    logic i_rst_n;

    ssym_req_if req_ch ();
    ssym_rsp_if rsp_ch ();

    scoped_symbol_stack uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    // Shadow copy of the stack contents, top count and scope depth.
    logic [F_KEY_W-1:0]   sym_keys   [TABLE_ENTRIES];
    logic [F_DEPTH_W-1:0] sym_depths [TABLE_ENTRIES];
    int                   sym_top;
    logic [F_DEPTH_W-1:0] sym_scope;

    t_result answers_due [$];

    int send_gap_pct;
    int sink_stall_pct;
    int err_count;
    int sent_count;
    int checked_count;
    int status_seen [6];

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Apply one request to the shadow stack and return the response it must give.
    function automatic t_result stack_apply(input t_op op, input logic [F_KEY_W-1:0] key,
                                            input logic [F_IDX_W-1:0] idx);
        t_result r;
        int      i;
        r        = '0;
        r.status = STAT_OK;
        r.depth  = sym_scope;
        case (op)
            OP_PUSH: begin
                if (sym_top >= TABLE_ENTRIES) begin
                    r.status = STAT_FULL;
                end else begin
                    sym_keys[sym_top]   = key;
                    sym_depths[sym_top] = sym_scope;
                    sym_top++;
                    r.key = key;
                end
            end
            OP_POP: begin
                if (sym_top == 0) begin
                    r.status = STAT_EMPTY;
                end else begin
                    sym_top--;
                    r.key   = sym_keys[sym_top];
                    r.depth = sym_depths[sym_top];
                end
            end
            OP_PEEK: begin
                if (sym_top == 0) begin
                    r.status = STAT_EMPTY;
                end else begin
                    r.key   = sym_keys[sym_top-1];
                    r.depth = sym_depths[sym_top-1];
                end
            end
            OP_READ: begin
                if (int'(idx) >= sym_top) begin
                    r.status = STAT_BAD_INDEX;
                end else begin
                    r.key   = sym_keys[idx];
                    r.depth = sym_depths[idx];
                end
            end
            OP_FIND: begin
                // newest match wins: walk down from the top
                for (i = sym_top - 1; i >= 0; i--) begin
                    if (sym_keys[i] == key) begin
                        r.found       = 1'b1;
                        r.found_index = F_IDX_W'(i);
                        break;
                    end
                end
            end
            OP_ENTER: begin
                if (sym_scope == '1) begin
                    r.status = STAT_DEPTH_OVF;
                end else begin
                    sym_scope++;
                    r.depth = sym_scope;
                end
            end
            OP_EXIT: begin
                if (sym_scope == 0) begin
                    r.status = STAT_DEPTH_LOW;
                end else begin
                    while (sym_top > 0 && sym_depths[sym_top-1] == sym_scope) sym_top--;
                    sym_scope--;
                    r.depth = sym_scope;
                end
            end
            OP_CLEAR: begin
                sym_top = 0;
            end
        endcase
        r.count = F_CNT_W'(sym_top);
        return r;
    endfunction

    task automatic note_mismatch(input string msg);
        err_count++;
        $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want)
            note_mismatch($sformatf("response %0d %s: expected %0h, got %0h",
                                    checked_count, name, want, got));
    endtask

    // Drive one request beat and hold it until the block takes it.
    task automatic send_req(input t_op op, input logic [F_KEY_W-1:0] key,
                            input logic [F_IDX_W-1:0] idx);
        t_result due;
        while ($urandom_range(99) < send_gap_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.req_type    <= op;
        req_ch.name_key    <= key;
        req_ch.entry_index <= idx;
        do @(posedge i_clk); while (!req_ch.ready);
        due = stack_apply(op, key, idx);
        answers_due.push_back(due);
        status_seen[int'(due.status)]++;
        sent_count++;
    endtask

    // Take response beats with random back-pressure and compare each one.
    initial begin
        t_result due;
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
                if (answers_due.size() == 0) begin
                    note_mismatch("response beat with no request outstanding");
                end else begin
                    due = answers_due.pop_front();
                    check_field("out_key", due.key, rsp_ch.out_key);
                    check_field("out_depth", 64'(due.depth), 64'(rsp_ch.out_depth));
                    check_field("found_index", 64'(due.found_index), 64'(rsp_ch.found_index));
                    check_field("found", 64'(due.found), 64'(rsp_ch.found));
                    check_field("entry_count", 64'(due.count), 64'(rsp_ch.entry_count));
                    check_field("status", 64'(due.status), 64'(rsp_ch.status));
                end
                checked_count++;
            end
            rsp_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    task automatic test_empty_and_basic;
        send_req(OP_POP, '0, '0);
        send_req(OP_PEEK, '0, '0);
        send_req(OP_READ, '0, '0);
        send_req(OP_FIND, '1, '0);
        send_req(OP_EXIT, '0, '0);
        send_req(OP_CLEAR, '0, '0);
        send_req(OP_PUSH, '0, '0);
        send_req(OP_PUSH, '1, '1);
        send_req(OP_PEEK, '0, '0);
        send_req(OP_READ, '0, 10'd0);
        send_req(OP_READ, '0, 10'd1);
        send_req(OP_READ, '0, 10'd2);
        send_req(OP_READ, '1, '1);
        send_req(OP_FIND, '1, '0);
        send_req(OP_FIND, '0, '0);
        send_req(OP_PUSH, '1, '0);
        send_req(OP_FIND, '1, '0);
        send_req(OP_POP, '0, '0);
        send_req(OP_FIND, 64'h5A5A_0F0F_C3C3_9669, '0);
    endtask

    task automatic test_scope_nesting;
        send_req(OP_ENTER, '0, '0);
        send_req(OP_PUSH, 64'hA1, '0);
        send_req(OP_ENTER, '0, '0);
        send_req(OP_PUSH, 64'hB2, '0);
        send_req(OP_PUSH, 64'hA1, '0);
        send_req(OP_FIND, 64'hA1, '0);
        send_req(OP_EXIT, '0, '0);
        send_req(OP_PEEK, '0, '0);
        send_req(OP_CLEAR, '0, '0);
        // empty stack at depth one: the first exit only drops the depth, the second hits depth zero
        send_req(OP_EXIT, '0, '0);
        send_req(OP_EXIT, '0, '0);
    endtask

    task automatic test_depth_limit;
        while (sym_scope != '1) send_req(OP_ENTER, {$urandom, $urandom}, '0);
        send_req(OP_ENTER, '0, '0);
        send_req(OP_PUSH, 64'hDEAD_BEEF_0000_0001, '0);
        repeat (24) send_req(OP_EXIT, {$urandom, $urandom}, '0);
    endtask

    task automatic test_random_mix(input int n);
        int                 r;
        t_op                op;
        logic [F_KEY_W-1:0] key;
        logic [F_IDX_W-1:0] idx;
        repeat (n) begin
            r   = $urandom_range(99);
            key = {$urandom, $urandom};
            idx = F_IDX_W'($urandom_range(TABLE_ENTRIES - 1));
            if (r < 32)      op = (sym_top > 48) ? OP_POP : OP_PUSH;
            else if (r < 42) op = OP_POP;
            else if (r < 50) op = OP_PEEK;
            else if (r < 62) op = OP_READ;
            else if (r < 77) op = OP_FIND;
            else if (r < 87) op = OP_ENTER;
            else if (r < 98) op = OP_EXIT;
            else             op = OP_CLEAR;
            // small keys and reused keys give duplicates and find hits
            if ($urandom_range(3) == 0)
                key = 64'($urandom_range(7));
            else if ((op == OP_FIND || op == OP_PUSH) && sym_top > 0 && $urandom_range(2) != 0)
                key = sym_keys[$urandom_range(sym_top - 1)];
            if (op == OP_READ && sym_top > 0 && $urandom_range(4) != 0)
                idx = F_IDX_W'($urandom_range(sym_top - 1));
            send_req(op, key, idx);
        end
    endtask

    initial begin
        i_rst_n            <= 1'b0;
        req_ch.valid       <= 1'b0;
        req_ch.req_type    <= OP_PUSH;
        req_ch.name_key    <= '0;
        req_ch.entry_index <= '0;
        sym_top            = 0;
        sym_scope          = '0;
        err_count          = 0;
        sent_count         = 0;
        checked_count      = 0;
        foreach (status_seen[k]) status_seen[k] = 0;
        send_gap_pct       = 19;
        sink_stall_pct     = 58;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_and_basic();
        test_scope_nesting();
        test_depth_limit();
        test_random_mix(90);
        send_gap_pct   = 58;
        sink_stall_pct = 19;
        test_random_mix(90);
        send_gap_pct   = 0;
        sink_stall_pct = 0;
        test_random_mix(90);

        req_ch.valid <= 1'b0;
        while (answers_due.size() != 0) @(posedge i_clk);
        repeat (TABLE_ENTRIES + 16) @(posedge i_clk);

        $display("%0d requests sent, %0d responses checked", sent_count, checked_count);
        $display("status mix: ok %0d, full %0d, empty %0d, bad index %0d,",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
        $display("            depth low %0d, overflow %0d", status_seen[4], status_seen[5]);
        if (err_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Hard stop far beyond the slowest legal run.
    initial begin
        #120000000;
        $display("timeout with %0d responses outstanding", answers_due.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule
